// ===== src/krwd_pkg.sv =====
`timescale 1ns / 1ps

package krwd_pkg;

  localparam int StampW = 32;
  localparam int GapW   = 16;
  localparam int KeysW  = 7;
  localparam int MinW   = 6;
  localparam int IdxW   = 2;
  localparam int CfgW   = 16;
  localparam int PcW    = 4;
  localparam int DivN   = 32;
  localparam int IterW  = 5;

  localparam logic [IdxW-1:0] REG_RATE_LIMIT = 2'd0;
  localparam logic [IdxW-1:0] REG_WINDOW     = 2'd1;
  localparam logic [IdxW-1:0] REG_MIN_KEYS   = 2'd2;

  localparam logic [CfgW-1:0] RATE_LIMIT_RST = 16'd35;
  localparam logic [CfgW-1:0] WINDOW_RST     = 16'd1000;
  localparam logic [MinW-1:0] MIN_KEYS_RST   = 6'd10;

  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_ACCEPT   = 4'd1;
  localparam logic [3:0] OP_EVICT    = 4'd2;
  localparam logic [3:0] OP_DROP     = 4'd3;
  localparam logic [3:0] OP_WRITE    = 4'd4;
  localparam logic [3:0] OP_DIV_INIT = 4'd5;
  localparam logic [3:0] OP_DIV_STEP = 4'd6;
  localparam logic [3:0] OP_OUTPUT   = 4'd7;

  localparam logic [2:0] C_NEXT        = 3'd0;
  localparam logic [2:0] C_ALWAYS      = 3'd1;
  localparam logic [2:0] C_NO_INPUT    = 3'd2;
  localparam logic [2:0] C_FEW         = 3'd3;
  localparam logic [2:0] C_STALE       = 3'd4;
  localparam logic [2:0] C_NOT_JUDGED  = 3'd5;
  localparam logic [2:0] C_DIV_MORE    = 3'd6;
  localparam logic [2:0] C_OUT_BLOCKED = 3'd7;

  typedef struct packed {
    logic [3:0]     op;
    logic [2:0]     cond;
    logic [PcW-1:0] target;
  } uop_t;

  function automatic uop_t ucode(input logic [PcW-1:0] pc);
    uop_t u;
    unique case (pc)
      4'd0:    u = '{OP_ACCEPT,   C_NO_INPUT,    4'd0};
      4'd1:    u = '{OP_NONE,     C_FEW,         4'd3};
      4'd2:    u = '{OP_EVICT,    C_STALE,       4'd1};
      4'd3:    u = '{OP_DROP,     C_NEXT,        4'd0};
      4'd4:    u = '{OP_WRITE,    C_NEXT,        4'd0};
      4'd5:    u = '{OP_NONE,     C_NOT_JUDGED,  4'd8};
      4'd6:    u = '{OP_DIV_INIT, C_NEXT,        4'd0};
      4'd7:    u = '{OP_DIV_STEP, C_DIV_MORE,    4'd7};
      4'd8:    u = '{OP_OUTPUT,   C_OUT_BLOCKED, 4'd8};
      default: u = '{OP_NONE,     C_ALWAYS,      4'd0};
    endcase
    return u;
  endfunction

endpackage

// ===== src/keystroke_rate_window_detector_unit.sv =====
`timescale 1ns / 1ps

// Sliding-window keystroke rate detector. Each request on s_* carries one
// key-down timestamp (ms, wrapping). One result per request leaves on m_*.
// A small microcode program steps a datapath around a RING_DEPTH-entry
// timestamp RAM. Stale stamps are evicted one at a time, each re-checked
// after a registered RAM read, the new stamp is appended, and the mean gap
// comes from a 32-step restoring divider that gives one quotient bit a cycle.
// The divider runs only when judged. The eviction check is skipped when at
// most one stamp is stored. Any wait on m_tready for the previous result
// delays the result. The next request is taken after the result is
// registered, and also while a result waits in the output register.
// Configuration writes take effect at once and belong in idle periods.
module keystroke_rate_window_detector_unit #(
  parameter int RING_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] key_time
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [0] alert, [1] judged, [17:2] mean_gap_ms,
                                 // [24:18] keys_in_window, [31:25] zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int PW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int JW = (CW > krwd_pkg::MinW) ? CW : krwd_pkg::MinW;

  logic [krwd_pkg::CfgW-1:0] rate_limit;
  logic [krwd_pkg::CfgW-1:0] window;
  logic [krwd_pkg::MinW-1:0] min_keys;

  logic [krwd_pkg::PcW-1:0]   pc;
  logic [krwd_pkg::PcW-1:0]   pc_next;
  krwd_pkg::uop_t             uop;
  logic [krwd_pkg::StampW-1:0] now;
  logic [PW-1:0]              ptr;
  logic [CW-1:0]              cnt;
  logic [krwd_pkg::StampW-1:0] quo;
  logic [CW-1:0]              rem;
  logic [krwd_pkg::IterW-1:0] iter;
  logic                       out_valid;
  logic [31:0]                out_data;

  logic [krwd_pkg::StampW-1:0] rdata;
  logic [krwd_pkg::StampW-1:0] age;
  logic [PW-1:0]              ptr_inc;
  logic [CW:0]                wsum;
  logic [PW-1:0]              waddr;
  logic                       ram_we;
  logic                       stale;
  logic                       judged;
  logic                       full;
  logic                       blocked;
  logic                       jump;
  logic [CW:0]                rem_sh;
  logic                       rem_ge;
  logic [krwd_pkg::GapW-1:0]  gap;
  logic                       alert;

  assign uop     = krwd_pkg::ucode(pc);
  assign age     = now - rdata;
  assign stale   = age > krwd_pkg::StampW'(window);
  assign judged  = JW'(cnt) > JW'(min_keys);
  assign full    = cnt == CW'(RING_DEPTH);
  assign blocked = out_valid && !m_tready;
  assign ptr_inc = (ptr == PW'(RING_DEPTH - 1)) ? '0 : ptr + 1'b1;
  assign wsum    = (CW + 1)'(ptr) + (CW + 1)'(cnt);
  assign waddr   = (wsum >= (CW + 1)'(RING_DEPTH)) ? PW'(wsum - (CW + 1)'(RING_DEPTH))
                                                   : PW'(wsum);
  assign ram_we  = uop.op == krwd_pkg::OP_WRITE;
  assign rem_sh  = {rem, quo[krwd_pkg::StampW-1]};
  assign rem_ge  = rem_sh >= (CW + 1)'(cnt);

  assign gap   = !judged ? '0 : (|quo[krwd_pkg::StampW-1:krwd_pkg::GapW]) ? '1
                                                          : quo[krwd_pkg::GapW-1:0];
  assign alert = judged && (gap < rate_limit);

  assign s_tready = uop.op == krwd_pkg::OP_ACCEPT;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_comb begin
    unique case (uop.cond)
      krwd_pkg::C_NEXT:        jump = 1'b0;
      krwd_pkg::C_ALWAYS:      jump = 1'b1;
      krwd_pkg::C_NO_INPUT:    jump = !s_tvalid;
      krwd_pkg::C_FEW:         jump = cnt <= CW'(1);
      krwd_pkg::C_STALE:       jump = stale;
      krwd_pkg::C_NOT_JUDGED:  jump = !judged;
      krwd_pkg::C_DIV_MORE:    jump = iter != krwd_pkg::IterW'(krwd_pkg::DivN - 1);
      krwd_pkg::C_OUT_BLOCKED: jump = blocked;
      default:                 jump = 1'b0;
    endcase
    pc_next = jump ? uop.target : pc + 1'b1;
  end

  krwd_ram #(
    .WIDTH(krwd_pkg::StampW),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata(now),
    .raddr(ptr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_limit <= krwd_pkg::RATE_LIMIT_RST;
      window     <= krwd_pkg::WINDOW_RST;
      min_keys   <= krwd_pkg::MIN_KEYS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        krwd_pkg::REG_RATE_LIMIT: rate_limit <= cfg_data;
        krwd_pkg::REG_WINDOW:     window     <= cfg_data;
        krwd_pkg::REG_MIN_KEYS:   min_keys   <= cfg_data[krwd_pkg::MinW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= '0;
      ptr       <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (uop.op == krwd_pkg::OP_OUTPUT && !blocked) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (uop.op)
        krwd_pkg::OP_EVICT: begin
          if (stale) begin
            ptr <= ptr_inc;
            cnt <= cnt - 1'b1;
          end
        end
        krwd_pkg::OP_DROP: begin
          if (full) begin
            ptr <= ptr_inc;
            cnt <= cnt - 1'b1;
          end
        end
        krwd_pkg::OP_WRITE:  cnt <= cnt + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (uop.op)
      krwd_pkg::OP_ACCEPT: begin
        if (s_tvalid) begin
          now <= s_tdata;
        end
      end
      krwd_pkg::OP_DIV_INIT: begin
        quo  <= age;
        rem  <= '0;
        iter <= '0;
      end
      krwd_pkg::OP_DIV_STEP: begin
        quo  <= {quo[krwd_pkg::StampW-2:0], rem_ge};
        rem  <= rem_ge ? CW'(rem_sh - (CW + 1)'(cnt)) : CW'(rem_sh);
        iter <= iter + 1'b1;
      end
      krwd_pkg::OP_OUTPUT: begin
        if (!blocked) begin
          out_data <= {7'd0, krwd_pkg::KeysW'(cnt), gap, judged, alert};
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== src/krwd_ram.sv =====
`timescale 1ns / 1ps

module krwd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
